// ----- design/psat_pkg.sv -----
`default_nettype none
package psat_pkg;

    // Store depth and the index and count widths that follow from it.
    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // Arithmetic widths.
    localparam int CRD_W = 32;   // Q16.16 coordinate
    localparam int OFF_W = 33;   // position minus origin
    localparam int NRM_W = 16;   // Q1.15 normal component
    localparam int WLD_W = 34;   // world coordinate
    localparam int PRD_W = 50;   // one product, Q.31
    localparam int DOT_W = 51;   // dot product, Q.31
    localparam int OVL_W = 52;   // overlap, Q.31
    localparam int OUT_W = 31;   // reported overlap, unsigned Q15.16
    localparam int FRAC_DROP = 15;

    localparam logic [OUT_W-1:0] SAT31 = {OUT_W{1'b1}};

    // What a projection request carries through the pipeline.
    typedef enum logic [1:0] {
        KIND_THIS,
        KIND_OTHER,
        KIND_DIR
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             test_init;
        logic             empty_pair;
        logic             pt_vld;
        t_kind            pt_kind;
        logic             pt_first;
        logic [IDX_W-1:0] pt_idx;
        logic             nrm_rd;
        logic             nrm_sel;     // 1 selects the other body's normals
        logic [IDX_W-1:0] nrm_idx;
        logic             axis_load;
        logic             out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_W-1:0] this_count;
        logic [CNT_W-1:0] other_count;
        logic             busy;
        logic             out_free;
    } t_stat;

endpackage
`default_nettype wire

// ----- design/psat_ctrl.sv -----
`default_nettype none
module psat_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_run_test,
    input  wire psat_pkg::t_stat i_stat,
    output psat_pkg::t_cmd       o_cmd,
    output logic                 o_stall
);
    import psat_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FETCH,
        S_LATCH,
        S_STREAM,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic             r_axis_sel, n_axis_sel;
    logic [IDX_W-1:0] r_axis_idx, n_axis_idx;
    t_kind            r_kind, n_kind;
    logic [IDX_W-1:0] r_pt_idx, n_pt_idx;

    logic [CNT_W-1:0] w_pt_next;
    logic [CNT_W-1:0] w_axis_next;
    logic             w_accept;

    assign w_accept    = i_valid && (r_state == S_IDLE);
    assign w_pt_next   = CNT_W'(r_pt_idx) + CNT_W'(1);
    assign w_axis_next = CNT_W'(r_axis_idx) + CNT_W'(1);
    assign o_stall     = (r_state != S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        n_axis_sel = r_axis_sel;
        n_axis_idx = r_axis_idx;
        n_kind     = r_kind;
        n_pt_idx   = r_pt_idx;
        o_cmd      = '0;
        o_cmd.pt_kind  = r_kind;
        o_cmd.pt_idx   = r_pt_idx;
        o_cmd.pt_first = (r_pt_idx == '0);
        o_cmd.nrm_sel  = r_axis_sel;
        o_cmd.nrm_idx  = r_axis_idx;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept && i_run_test) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.test_init  = 1'b1;
                n_axis_sel       = 1'b1;
                n_axis_idx       = '0;
                if (i_stat.this_count == '0 || i_stat.other_count == '0) begin
                    o_cmd.empty_pair = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.nrm_rd = 1'b1;
                n_state      = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.axis_load = 1'b1;
                n_kind          = KIND_THIS;
                n_pt_idx        = '0;
                n_state         = S_STREAM;
            end
            S_STREAM: begin
                o_cmd.pt_vld = 1'b1;
                case (r_kind)
                    KIND_THIS: begin
                        if (w_pt_next == i_stat.this_count) begin
                            n_kind   = KIND_OTHER;
                            n_pt_idx = '0;
                        end else begin
                            n_pt_idx = r_pt_idx + IDX_W'(1);
                        end
                    end
                    KIND_OTHER: begin
                        if (w_pt_next == i_stat.other_count) begin
                            n_kind = KIND_DIR;
                        end else begin
                            n_pt_idx = r_pt_idx + IDX_W'(1);
                        end
                    end
                    default: begin
                        n_state = S_DRAIN;
                    end
                endcase
            end
            S_DRAIN: begin
                // Wait for the axis to leave the pipeline, then pick the next one.
                if (!i_stat.busy) begin
                    if (r_axis_sel) begin
                        if (w_axis_next == i_stat.other_count) begin
                            n_axis_sel = 1'b0;
                            n_axis_idx = '0;
                        end else begin
                            n_axis_idx = r_axis_idx + IDX_W'(1);
                        end
                        n_state = S_FETCH;
                    end else if (w_axis_next == i_stat.this_count) begin
                        n_state = S_DONE;
                    end else begin
                        n_axis_idx = r_axis_idx + IDX_W'(1);
                        n_state    = S_FETCH;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_axis_sel <= 1'b0;
            r_axis_idx <= '0;
            r_kind     <= KIND_THIS;
            r_pt_idx   <= '0;
        end else begin
            r_state    <= n_state;
            r_axis_sel <= n_axis_sel;
            r_axis_idx <= n_axis_idx;
            r_kind     <= n_kind;
            r_pt_idx   <= n_pt_idx;
        end
    end

endmodule
`default_nettype wire

// ----- design/psat_dp.sv -----
`default_nettype none
module psat_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire psat_pkg::t_cmd                 i_cmd,
    output psat_pkg::t_stat                     o_stat,
    input  wire logic                           i_body_select,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_point_x,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_point_y,
    input  wire logic signed [psat_pkg::NRM_W-1:0] i_normal_x,
    input  wire logic signed [psat_pkg::NRM_W-1:0] i_normal_y,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_pos_x,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_pos_y,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_origin_x,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_origin_y,
    input  wire logic                           i_stall,
    output logic                                o_valid,
    output logic                                o_collided,
    output logic [psat_pkg::OUT_W-1:0]          o_min_overlap,
    output logic signed [psat_pkg::NRM_W-1:0]   o_push_axis_x,
    output logic signed [psat_pkg::NRM_W-1:0]   o_push_axis_y,
    output logic                                o_vertex_overflow
);
    import psat_pkg::*;

    localparam logic signed [NRM_W-1:0] NRM_MIN = {1'b1, {(NRM_W-1){1'b0}}};
    localparam logic signed [NRM_W-1:0] NRM_MAX = {1'b0, {(NRM_W-1){1'b1}}};

    // Vertex and normal stores.
    logic [2*CRD_W-1:0] this_pts  [MAX_VERTICES];
    logic [2*CRD_W-1:0] other_pts [MAX_VERTICES];
    logic [2*NRM_W-1:0] this_nrm  [MAX_VERTICES];
    logic [2*NRM_W-1:0] other_nrm [MAX_VERTICES];

    logic [CNT_W-1:0] r_this_count, r_other_count;
    logic             r_overflow;

    logic signed [CRD_W-1:0] r_this_pos_x, r_this_pos_y, r_other_pos_x, r_other_pos_y;
    logic signed [OFF_W-1:0] r_this_off_x, r_this_off_y, r_other_off_x, r_other_off_y;
    logic signed [OFF_W-1:0] w_off_x, w_off_y;

    logic w_this_wr, w_other_wr;

    assign w_off_x    = OFF_W'(i_body_pos_x) - OFF_W'(i_body_origin_x);
    assign w_off_y    = OFF_W'(i_body_pos_y) - OFF_W'(i_body_origin_y);
    assign w_this_wr  = i_cmd.load && !i_body_select
                        && (r_this_count < CNT_W'(MAX_VERTICES));
    assign w_other_wr = i_cmd.load && i_body_select
                        && (r_other_count < CNT_W'(MAX_VERTICES));

    // Store writes.
    always_ff @(posedge i_clk) begin
        if (w_this_wr) begin
            this_pts[r_this_count[IDX_W-1:0]] <= {i_point_y, i_point_x};
            this_nrm[r_this_count[IDX_W-1:0]] <= {i_normal_y, i_normal_x};
        end
        if (w_other_wr) begin
            other_pts[r_other_count[IDX_W-1:0]] <= {i_point_y, i_point_x};
            other_nrm[r_other_count[IDX_W-1:0]] <= {i_normal_y, i_normal_x};
        end
    end

    // Placement of each body, kept as position and as position minus origin.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_body_select) begin
                r_other_pos_x <= i_body_pos_x;
                r_other_pos_y <= i_body_pos_y;
                r_other_off_x <= w_off_x;
                r_other_off_y <= w_off_y;
            end else begin
                r_this_pos_x <= i_body_pos_x;
                r_this_pos_y <= i_body_pos_y;
                r_this_off_x <= w_off_x;
                r_this_off_y <= w_off_y;
            end
        end
    end

    // Fill counts and the overflow flag; a finished test starts a new pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_this_count  <= '0;
            r_other_count <= '0;
            r_overflow    <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_this_count  <= '0;
            r_other_count <= '0;
            r_overflow    <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_this_wr) begin
                r_this_count <= r_this_count + CNT_W'(1);
            end else if (w_other_wr) begin
                r_other_count <= r_other_count + CNT_W'(1);
            end else begin
                r_overflow <= 1'b1;
            end
        end
    end

    // Stage 0: registered store reads.
    logic [2*CRD_W-1:0] r_t_pt, r_o_pt;
    logic [2*NRM_W-1:0] r_t_nrm, r_o_nrm;
    logic               r_nrm_sel;
    logic               r_s0_vld, r_s0_first;
    t_kind              r_s0_kind;

    always_ff @(posedge i_clk) begin
        r_t_pt <= this_pts[i_cmd.pt_idx];
        r_o_pt <= other_pts[i_cmd.pt_idx];
        if (i_cmd.nrm_rd) begin
            r_t_nrm   <= this_nrm[i_cmd.nrm_idx];
            r_o_nrm   <= other_nrm[i_cmd.nrm_idx];
            r_nrm_sel <= i_cmd.nrm_sel;
        end
    end

    // Current axis.
    logic signed [NRM_W-1:0] r_ax, r_ay;

    always_ff @(posedge i_clk) begin
        if (i_cmd.axis_load) begin
            r_ax <= r_nrm_sel ? r_o_nrm[NRM_W-1:0] : r_t_nrm[NRM_W-1:0];
            r_ay <= r_nrm_sel ? r_o_nrm[2*NRM_W-1:NRM_W] : r_t_nrm[2*NRM_W-1:NRM_W];
        end
    end

    // Stage 1: world coordinates, or the placement difference for the direction.
    logic signed [WLD_W-1:0] n_wx, n_wy, r_wx, r_wy;
    logic                    r_s1_vld, r_s1_first;
    t_kind                   r_s1_kind;

    always_comb begin
        case (r_s0_kind)
            KIND_THIS: begin
                n_wx = WLD_W'($signed(r_t_pt[CRD_W-1:0])) + WLD_W'(r_this_off_x);
                n_wy = WLD_W'($signed(r_t_pt[2*CRD_W-1:CRD_W])) + WLD_W'(r_this_off_y);
            end
            KIND_OTHER: begin
                n_wx = WLD_W'($signed(r_o_pt[CRD_W-1:0])) + WLD_W'(r_other_off_x);
                n_wy = WLD_W'($signed(r_o_pt[2*CRD_W-1:CRD_W])) + WLD_W'(r_other_off_y);
            end
            default: begin
                n_wx = WLD_W'(r_this_pos_x) - WLD_W'(r_other_pos_x);
                n_wy = WLD_W'(r_this_pos_y) - WLD_W'(r_other_pos_y);
            end
        endcase
    end

    // Stage 2: products; stage 3: dot product.
    logic signed [PRD_W-1:0] r_px, r_py;
    logic                    r_s2_vld, r_s2_first;
    t_kind                   r_s2_kind;
    logic signed [DOT_W-1:0] r_d;
    logic                    r_s3_vld, r_s3_first;
    t_kind                   r_s3_kind;

    always_ff @(posedge i_clk) begin
        r_wx <= n_wx;
        r_wy <= n_wy;
        r_px <= PRD_W'(r_wx) * PRD_W'(r_ax);
        r_py <= PRD_W'(r_wy) * PRD_W'(r_ay);
        r_d  <= DOT_W'(r_px) + DOT_W'(r_py);
        r_s0_kind  <= i_cmd.pt_kind;
        r_s0_first <= i_cmd.pt_first;
        r_s1_kind  <= r_s0_kind;
        r_s1_first <= r_s0_first;
        r_s2_kind  <= r_s1_kind;
        r_s2_first <= r_s1_first;
        r_s3_kind  <= r_s2_kind;
        r_s3_first <= r_s2_first;
    end

    // Pipeline occupancy.
    logic r_ov_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_ov_vld <= 1'b0;
        end else begin
            r_s0_vld <= i_cmd.pt_vld;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_ov_vld <= r_s3_vld && (r_s3_kind == KIND_DIR);
        end
    end

    // Stage 4: projection extents per body; the direction request closes the axis.
    logic signed [DOT_W-1:0] r_tmn, r_tmx, r_omn, r_omx;
    logic signed [DOT_W-1:0] w_hi, w_lo;
    logic signed [OVL_W-1:0] r_ov;
    logic                    r_neg;

    assign w_hi = (r_tmx < r_omx) ? r_tmx : r_omx;
    assign w_lo = (r_tmn > r_omn) ? r_tmn : r_omn;

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            case (r_s3_kind)
                KIND_THIS: begin
                    if (r_s3_first || r_d < r_tmn) r_tmn <= r_d;
                    if (r_s3_first || r_d > r_tmx) r_tmx <= r_d;
                end
                KIND_OTHER: begin
                    if (r_s3_first || r_d < r_omn) r_omn <= r_d;
                    if (r_s3_first || r_d > r_omx) r_omx <= r_d;
                end
                default: begin
                    r_ov  <= OVL_W'(w_hi) - OVL_W'(w_lo);
                    r_neg <= r_d[DOT_W-1];
                end
            endcase
        end
    end

    // Stage 5: keep the smallest positive overlap and its turned axis.
    logic                    r_coll, r_found;
    logic signed [OVL_W-1:0] r_best;
    logic signed [NRM_W-1:0] r_bax, r_bay, w_nax, w_nay;

    assign w_nax = (r_ax == NRM_MIN) ? NRM_MAX : -r_ax;
    assign w_nay = (r_ay == NRM_MIN) ? NRM_MAX : -r_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.test_init) begin
            r_coll  <= !i_cmd.empty_pair;
            r_found <= 1'b0;
        end else if (r_ov_vld) begin
            if (r_ov > OVL_W'(0)) begin
                if (!r_found || r_ov < r_best) begin
                    r_found <= 1'b1;
                    r_best  <= r_ov;
                    r_bax   <= r_neg ? w_nax : r_ax;
                    r_bay   <= r_neg ? w_nay : r_ay;
                end
            end else begin
                r_coll <= 1'b0;
            end
        end
    end

    // Result register.
    logic [OVL_W-FRAC_DROP-1:0] w_q;
    logic [OUT_W-1:0]           w_min;
    logic                       r_out_vld;

    assign w_q   = r_best[OVL_W-1:FRAC_DROP];
    assign w_min = !r_found ? SAT31
                 : (w_q > (OVL_W-FRAC_DROP)'(SAT31)) ? SAT31 : w_q[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_collided        <= r_coll;
            o_min_overlap     <= w_min;
            o_push_axis_x     <= r_found ? r_bax : '0;
            o_push_axis_y     <= r_found ? r_bay : '0;
            o_vertex_overflow <= r_overflow;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_stat.this_count  = r_this_count;
    assign o_stat.other_count = r_other_count;
    assign o_stat.busy        = r_s0_vld | r_s1_vld | r_s2_vld | r_s3_vld | r_ov_vld;
    assign o_stat.out_free    = !r_out_vld || !i_stall;

endmodule
`default_nettype wire

// ----- design/polygon_sat_collision.sv -----
// Separating-axis overlap test of two convex polygons.
// Input channel (i_valid / o_stall): each request loads one vertex with its
// edge normal into the store of the body that i_body_select names, together
// with that body's position and origin. Up to 16 vertices per body are kept;
// further ones are dropped and flagged. A request with i_run_test set is
// stored and then starts the test; o_stall stays high until its result has
// been placed in the output register.
// Output channel (o_valid / i_stall): one result per test request. The result
// register holds while i_stall is high; new vertex loads are still taken then.
// A test projects both bodies onto every axis (each normal of both bodies),
// one axis at a time: the single projection pipeline (store read, world add,
// multiply, dot sum, extents) drains before the next axis starts.
// An empty body skips the axes.
// Reset clears the vertex counts, the overflow flag and the pipeline; the
// stores themselves are not cleared.
`default_nettype none
module polygon_sat_collision (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_body_select,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_point_x,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_point_y,
    input  wire logic signed [psat_pkg::NRM_W-1:0] i_normal_x,
    input  wire logic signed [psat_pkg::NRM_W-1:0] i_normal_y,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_pos_x,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_pos_y,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_origin_x,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_origin_y,
    input  wire logic                              i_run_test,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_collided,
    output logic [psat_pkg::OUT_W-1:0]             o_min_overlap,
    output logic signed [psat_pkg::NRM_W-1:0]      o_push_axis_x,
    output logic signed [psat_pkg::NRM_W-1:0]      o_push_axis_y,
    output logic                                   o_vertex_overflow
);
    import psat_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer.
    psat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_run_test (i_run_test),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_stall    (o_stall)
    );

    // Stores, projection pipeline and result register.
    psat_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_body_select     (i_body_select),
        .i_point_x         (i_point_x),
        .i_point_y         (i_point_y),
        .i_normal_x        (i_normal_x),
        .i_normal_y        (i_normal_y),
        .i_body_pos_x      (i_body_pos_x),
        .i_body_pos_y      (i_body_pos_y),
        .i_body_origin_x   (i_body_origin_x),
        .i_body_origin_y   (i_body_origin_y),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_collided        (o_collided),
        .o_min_overlap     (o_min_overlap),
        .o_push_axis_x     (o_push_axis_x),
        .o_push_axis_y     (o_push_axis_y),
        .o_vertex_overflow (o_vertex_overflow)
    );

endmodule
`default_nettype wire

// ----- design/psat_checker.sv -----
`default_nettype none
module psat_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_valid,
    input wire logic                              o_stall,
    input wire logic                              i_run_test,
    input wire logic                              o_valid,
    input wire logic                              i_stall,
    input wire logic                              o_collided,
    input wire logic [psat_pkg::OUT_W-1:0]        o_min_overlap,
    input wire logic signed [psat_pkg::NRM_W-1:0] o_push_axis_x,
    input wire logic signed [psat_pkg::NRM_W-1:0] o_push_axis_y
);
    import psat_pkg::*;

    // A test request blocks further requests while it runs.
    a_test_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_run_test |=> o_stall)
        else $error("input not stalled after a test request");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_collided)
                               && $stable(o_min_overlap))
        else $error("stalled result changed");

    // A hit always carries a nonzero push axis.
    a_hit_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_collided |-> (o_push_axis_x != '0 || o_push_axis_y != '0))
        else $error("hit reported without a push axis");

endmodule

bind polygon_sat_collision psat_checker u_psat_checker (.*);
`default_nettype wire

// ----- tb/sv/polygon_sat_collision_checker.sv -----
`default_nettype none
module polygon_sat_collision_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic                              o_stall,
    input  wire logic                              i_body_select,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_point_x,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_point_y,
    input  wire logic signed [psat_pkg::NRM_W-1:0] i_normal_x,
    input  wire logic signed [psat_pkg::NRM_W-1:0] i_normal_y,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_pos_x,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_pos_y,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_origin_x,
    input  wire logic signed [psat_pkg::CRD_W-1:0] i_body_origin_y,
    input  wire logic                              i_run_test,
    input  wire logic                              o_valid,
    input  wire logic                              i_stall,
    input  wire logic                              o_collided,
    input  wire logic [psat_pkg::OUT_W-1:0]        o_min_overlap,
    input  wire logic signed [psat_pkg::NRM_W-1:0] o_push_axis_x,
    input  wire logic signed [psat_pkg::NRM_W-1:0] o_push_axis_y,
    input  wire logic                              o_vertex_overflow,
    output int                                     o_fail_count,
    output int                                     o_pending,
    output int                                     o_result_count,
    output int                                     o_hit_count,
    output int                                     o_overflow_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import psat_pkg::*;

    localparam int BODY_THIS  = 0;
    localparam int BODY_OTHER = 1;

    typedef struct packed {
        logic                    collided;
        logic [OUT_W-1:0]        overlap;
        logic signed [NRM_W-1:0] axis_x;
        logic signed [NRM_W-1:0] axis_y;
        logic                    overflow;
    } t_sat_result;

    // Shadow copy of the vertex stores and placements, indexed by body.
    logic signed [CRD_W-1:0] vert_x [2][MAX_VERTICES];
    logic signed [CRD_W-1:0] vert_y [2][MAX_VERTICES];
    logic signed [NRM_W-1:0] norm_x [2][MAX_VERTICES];
    logic signed [NRM_W-1:0] norm_y [2][MAX_VERTICES];
    int                      vert_count [2];
    logic signed [CRD_W-1:0] pos_x [2];
    logic signed [CRD_W-1:0] pos_y [2];
    logic signed [CRD_W-1:0] org_x [2];
    logic signed [CRD_W-1:0] org_y [2];
    logic                    dropped;

    t_sat_result sat_results_q [$];

    // Extent of one body's world points along an axis.
    function automatic void body_extent(input int b, input longint ax, input longint ay,
                                        output longint lo, output longint hi);
        longint ox, oy, d;
        ox = longint'(pos_x[b]) - longint'(org_x[b]);
        oy = longint'(pos_y[b]) - longint'(org_y[b]);
        lo = 0;
        hi = 0;
        for (int i = 0; i < vert_count[b]; i++) begin
            d = (longint'(vert_x[b][i]) + ox) * ax + (longint'(vert_y[b][i]) + oy) * ay;
            if (i == 0 || d < lo) lo = d;
            if (i == 0 || d > hi) hi = d;
        end
    endfunction

    // Separating-axis test over the other body's normals, then this body's.
    function automatic t_sat_result sat_test();
        t_sat_result r;
        longint ax, ay, tlo, thi, olo, ohi, ov, best, dx, dy, q;
        bit found;
        int b, k;
        r = '0;
        r.collided = 1'b1;
        found = 0;
        best = 0;
        if (vert_count[BODY_THIS] == 0 || vert_count[BODY_OTHER] == 0) begin
            r.collided = 1'b0;
        end else begin
            for (int i = 0; i < vert_count[BODY_OTHER] + vert_count[BODY_THIS]; i++) begin
                b = (i < vert_count[BODY_OTHER]) ? BODY_OTHER : BODY_THIS;
                k = (i < vert_count[BODY_OTHER]) ? i : i - vert_count[BODY_OTHER];
                ax = longint'(norm_x[b][k]);
                ay = longint'(norm_y[b][k]);
                body_extent(BODY_THIS, ax, ay, tlo, thi);
                body_extent(BODY_OTHER, ax, ay, olo, ohi);
                ov = ((thi < ohi) ? thi : ohi) - ((tlo > olo) ? tlo : olo);
                if (ov > 0) begin
                    if (!found || ov < best) begin
                        found = 1;
                        best = ov;
                        dx = longint'(pos_x[BODY_THIS]) - longint'(pos_x[BODY_OTHER]);
                        dy = longint'(pos_y[BODY_THIS]) - longint'(pos_y[BODY_OTHER]);
                        // Point the axis from the other body toward this one.
                        if (dx * ax + dy * ay < 0) begin
                            ax = (ax == -32768) ? 32767 : -ax;
                            ay = (ay == -32768) ? 32767 : -ay;
                        end
                        r.axis_x = NRM_W'(ax);
                        r.axis_y = NRM_W'(ay);
                    end
                end else begin
                    r.collided = 1'b0;
                end
            end
        end
        if (found) begin
            q = best >>> FRAC_DROP;
            r.overlap = (q > longint'(SAT31)) ? SAT31 : OUT_W'(q);
        end else begin
            r.overlap = SAT31;
        end
        r.overflow = dropped;
        return r;
    endfunction

    // Compare delivered results, then fold each accepted request into the shadow state.
    always @(posedge i_clk) begin
        t_sat_result got, want;
        int b;
        if (!i_rst_n) begin
            vert_count[0] = 0;
            vert_count[1] = 0;
            for (int i = 0; i < 2; i++) begin
                pos_x[i] = '0;
                pos_y[i] = '0;
                org_x[i] = '0;
                org_y[i] = '0;
            end
            dropped = 1'b0;
            o_fail_count <= 0;
            o_result_count <= 0;
            o_hit_count <= 0;
            o_overflow_count <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_collided, o_min_overlap, o_push_axis_x, o_push_axis_y,
                       o_vertex_overflow};
                o_result_count <= o_result_count + 1;
                if (sat_results_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result col=%0b ovl=%h ax=%0d ay=%0d ovf=%0b",
                                 $realtime, got.collided, got.overlap, got.axis_x,
                                 got.axis_y, got.overflow);
                end else begin
                    want = sat_results_q.pop_front();
                    if (want.collided) o_hit_count <= o_hit_count + 1;
                    if (want.overflow) o_overflow_count <= o_overflow_count + 1;
                    if (got != want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display({"%0t: mismatch col=%0b/%0b ovl=%h/%h ",
                                      "ax=%0d/%0d ay=%0d/%0d ovf=%0b/%0b (expected/actual)"},
                                     $realtime, want.collided, got.collided, want.overlap,
                                     got.overlap, want.axis_x, got.axis_x, want.axis_y,
                                     got.axis_y, want.overflow, got.overflow);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                b = i_body_select ? BODY_OTHER : BODY_THIS;
                pos_x[b] = i_body_pos_x;
                pos_y[b] = i_body_pos_y;
                org_x[b] = i_body_origin_x;
                org_y[b] = i_body_origin_y;
                if (vert_count[b] < MAX_VERTICES) begin
                    vert_x[b][vert_count[b]] = i_point_x;
                    vert_y[b][vert_count[b]] = i_point_y;
                    norm_x[b][vert_count[b]] = i_normal_x;
                    norm_y[b][vert_count[b]] = i_normal_y;
                    vert_count[b]++;
                end else begin
                    dropped = 1'b1;
                end
                if (i_run_test) begin
                    sat_results_q.push_back(sat_test());
                    vert_count[0] = 0;
                    vert_count[1] = 0;
                    dropped = 1'b0;
                end
            end
        end
        o_pending <= sat_results_q.size();
    end

endmodule
`default_nettype wire

// ----- tb/sv/polygon_sat_collision_tb.sv -----
`default_nettype none
module polygon_sat_collision_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psat_pkg::*;

    localparam int ONE = 65536;  // 1.0 in Q16.16
    localparam logic signed [NRM_W-1:0] N_POS  = 16'sd32767;
    localparam logic signed [NRM_W-1:0] N_NEG  = -16'sd32768;
    localparam logic signed [NRM_W-1:0] N_DIAG = 16'sd23170;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_body_select = 1'b0;
    logic signed [CRD_W-1:0] i_point_x = '0;
    logic signed [CRD_W-1:0] i_point_y = '0;
    logic signed [NRM_W-1:0] i_normal_x = '0;
    logic signed [NRM_W-1:0] i_normal_y = '0;
    logic signed [CRD_W-1:0] i_body_pos_x = '0;
    logic signed [CRD_W-1:0] i_body_pos_y = '0;
    logic signed [CRD_W-1:0] i_body_origin_x = '0;
    logic signed [CRD_W-1:0] i_body_origin_y = '0;
    logic                    i_run_test = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_collided;
    logic [OUT_W-1:0]        o_min_overlap;
    logic signed [NRM_W-1:0] o_push_axis_x;
    logic signed [NRM_W-1:0] o_push_axis_y;
    logic                    o_vertex_overflow;

    int fail_count, pending, result_count, hit_count, overflow_count;
    int requests_sent = 0;
    int stall_hold = 0;
    bit no_gaps = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    polygon_sat_collision dut (.*);

    polygon_sat_collision_checker checker_inst (
        .*,
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_hit_count     (hit_count),
        .o_overflow_count(overflow_count)
    );

    // Result side back-pressure: long quiet stretches, short stalls, a few long ones.
    always @(negedge i_clk) begin
        int r;
        if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_stall = 1'b0;
                stall_hold = $urandom_range(0, 20);
            end else if (r < 95) begin
                i_stall = 1'b1;
                stall_hold = $urandom_range(0, 3);
            end else begin
                i_stall = 1'b1;
                stall_hold = $urandom_range(20, 60);
            end
        end
    end

    // Present one vertex request and hold it until the block takes it.
    task automatic send_vertex(input logic bsel, input logic signed [CRD_W-1:0] px, py,
                               input logic signed [NRM_W-1:0] nx, ny,
                               input logic signed [CRD_W-1:0] bx, by, ox, oy,
                               input logic run);
        int r, gap;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_body_select = bsel;
        i_point_x = px;
        i_point_y = py;
        i_normal_x = nx;
        i_normal_y = ny;
        i_body_pos_x = bx;
        i_body_pos_y = by;
        i_body_origin_x = ox;
        i_body_origin_y = oy;
        i_run_test = run;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
        r = $urandom_range(0, 99);
        gap = no_gaps ? 0 : (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Box or diamond around the local origin, with near-unit edge normals.
    task automatic send_shape(input logic bsel, input bit diamond, input int hw, hh,
                              input logic signed [CRD_W-1:0] bx, by, ox, oy,
                              input bit run_last);
        logic signed [CRD_W-1:0] vx [4];
        logic signed [CRD_W-1:0] vy [4];
        logic signed [NRM_W-1:0] nx [4];
        logic signed [NRM_W-1:0] ny [4];
        if (diamond) begin
            vx = '{hw, 0, -hw, 0};
            vy = '{0, hh, 0, -hh};
            nx = '{N_DIAG, -N_DIAG, -N_DIAG, N_DIAG};
            ny = '{N_DIAG, N_DIAG, -N_DIAG, -N_DIAG};
        end else begin
            vx = '{hw, -hw, -hw, hw};
            vy = '{hh, hh, -hh, -hh};
            nx = '{N_POS, '0, ($urandom_range(0, 1) ? N_NEG : -N_POS), '0};
            ny = '{'0, N_POS, '0, ($urandom_range(0, 1) ? N_NEG : -N_POS)};
        end
        for (int i = 0; i < 4; i++)
            send_vertex(bsel, vx[i] + ox, vy[i] + oy, nx[i], ny[i], bx, by, ox, oy,
                        run_last && i == 3);
    endtask

    task automatic send_noise(input logic run);
        send_vertex(1'($urandom_range(0, 1)), $urandom, $urandom,
                    NRM_W'($urandom), NRM_W'($urandom),
                    $urandom, $urandom, $urandom, $urandom, run);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (pending == 0 && !o_valid);
    endtask

    // Two shapes near each other so that some pairs touch and some do not.
    task automatic send_shape_pair();
        int s;
        logic signed [CRD_W-1:0] ox, oy;
        s = $urandom_range(20, 120) * ONE;
        ox = $urandom_range(0, 1) ? 0 : $signed($urandom_range(0, 50 * ONE)) - 25 * ONE;
        oy = $urandom_range(0, 1) ? 0 : $signed($urandom_range(0, 50 * ONE)) - 25 * ONE;
        send_shape(1'b0, 1'($urandom_range(0, 1)), $urandom_range(ONE, 60 * ONE),
                   $urandom_range(ONE, 60 * ONE), $urandom_range(0, 2 * s) - s,
                   $urandom_range(0, 2 * s) - s, ox, oy, 0);
        send_shape(1'b1, 1'($urandom_range(0, 1)), $urandom_range(ONE, 60 * ONE),
                   $urandom_range(ONE, 60 * ONE), $urandom_range(0, 2 * s) - s,
                   $urandom_range(0, 2 * s) - s, 0, 0, 1);
    endtask

    initial begin
        int r, n;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty body on either side, at the field extremes.
        send_vertex(1'b0, 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 16'sh7fff,
                    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
        send_vertex(1'b1, 32'sh80000000, 32'sh80000000, N_NEG, N_NEG,
                    32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1);
        // Axis of -1,-1 turned toward this body saturates to +1,+1.
        send_vertex(1'b0, 0, 0, N_NEG, N_NEG, 5 * ONE, 5 * ONE, 0, 0, 0);
        send_vertex(1'b0, 10 * ONE, 10 * ONE, N_NEG, N_NEG, 5 * ONE, 5 * ONE, 0, 0, 0);
        send_vertex(1'b1, 0, 0, N_NEG, N_NEG, 0, 0, 0, 0, 0);
        send_vertex(1'b1, 10 * ONE, 10 * ONE, N_NEG, N_NEG, 0, 0, 0, 0, 1);
        // No axis overlaps at all: bodies far apart along the only axis.
        send_vertex(1'b0, 0, 0, N_POS, '0, 1000 * ONE, 0, 0, 0, 0);
        send_vertex(1'b1, 0, 0, N_POS, '0, 0, 0, 0, 0, 1);
        // Overlapping boxes, then a diamond clearly separated from a box.
        send_shape(1'b0, 0, 10 * ONE, 10 * ONE, 5 * ONE, 3 * ONE, 0, 0, 0);
        send_shape(1'b1, 0, 10 * ONE, 10 * ONE, 0, 0, 0, 0, 1);
        send_shape(1'b0, 1, 10 * ONE, 10 * ONE, 300 * ONE, 0, ONE, ONE, 0);
        send_shape(1'b1, 0, 10 * ONE, 10 * ONE, 0, 0, 0, 0, 1);
        drain_results();

        // Random part: mostly well formed shape pairs, with noise and overflow.
        n = 0;
        while (requests_sent < 560) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_shape_pair();
            end else if (r < 85) begin
                repeat ($urandom_range(1, 6)) send_noise(0);
                send_noise(1);
            end else if (r < 93) begin
                // Send more vertices than one store holds, split at random between the bodies.
                repeat ($urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 4)) send_noise(0);
                send_noise(1);
            end else begin
                send_noise(1'($urandom_range(0, 1)));
            end
            n++;
            if (n % 12 == 0) drain_results();
        end
        no_gaps = 0;

        drain_results();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d vertex requests; %0d tests checked, %0d hits, %0d with overflow.",
                 requests_sent, result_count, hit_count, overflow_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    initial begin
        #100ms;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
